// ===== design/tcc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the text console engine
// no dependencies; every other design file refers to this package by scope

package tcc_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int CODE_W     = 8;
    localparam int COL_IN_W   = 7;
    localparam int ROW_IN_W   = 5;
    localparam int CELL_W     = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // character codes and attributes
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CODE_W-1:0] NUL_CODE     = 8'd0;
    localparam logic [CODE_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0]        RESET_ATTR   = 8'd15;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};

    // register map
    localparam logic [0:0] REG_TEXT_ATTR = 1'b0;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_GOTO  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_PUT     = 3'd1,
        OP_NEWLINE = 3'd2,
        OP_GOTO    = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    localparam int OP_W = $bits(op_t);

    typedef enum logic [2:0] {
        ST_INIT   = 3'd0,
        ST_IDLE   = 3'd1,
        ST_READ   = 3'd2,
        ST_SCROLL = 3'd3,
        ST_BLANK  = 3'd4,
        ST_CLEAR  = 3'd5
    } state_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

// ===== design/text_console_cursor_scroll.sv =====
`timescale 1ns / 1ps
// top level of the text console engine: config register, front, queue, back
// depends on tcc_pkg, tcc_front, tcc_fifo, tcc_back

// text console engine with a COLUMNS x ROWS screen store of 16-bit cells
// (character in bits 7..0, attribute in bits 15..8) and a cursor. each input
// word carries one command and gives exactly one result word. the front end
// classifies and clamps commands into a two-word queue, so it keeps taking
// words while the back end works or a result waits, until the queue is full.
// the back end owns the screen memory, which has one write and one read port,
// and that port sets the timing: puts and newlines that do not scroll, gotos
// and ignored codes finish as they are taken, a cell read goes through the
// registered read port, a put or newline that scrolls copies every row up one
// cell per cycle and then blanks the bottom row, and a clear writes every
// cell. after reset the back end runs a clearing pass that fills the screen
// with spaces in attribute 15; item_ready stays low until it is done, while
// the config port works as ever. text_attr is decoded from paddr bit 2 alone:
// byte addresses 0 to 3 reach it, and writes to addresses 4 to 7 are dropped.

module text_console_cursor_scroll #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input word
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [tcc_pkg::CMD_W-1:0]     cmd,
    input  logic [tcc_pkg::CODE_W-1:0]    char_code,
    input  logic [tcc_pkg::COL_IN_W-1:0]  col,
    input  logic [tcc_pkg::ROW_IN_W-1:0]  row,
    // result word
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tcc_pkg::COL_IN_W-1:0]  cursor_x,
    output logic [tcc_pkg::ROW_IN_W-1:0]  cursor_y,
    output logic [7:0]                    cell_char,
    output logic [7:0]                    cell_attr,
    output logic                          scrolled
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    // queue word: op, code, column, row
    localparam int Q_W   = tcc_pkg::OP_W + tcc_pkg::CODE_W + COL_W + ROW_W;

    logic [7:0] attr_reg, attr_next;
    logic       cfg_hit;

    tcc_pkg::fifo_status_t          q_status;
    tcc_pkg::back_status_t          b_status;
    logic                           push, pop;
    tcc_pkg::op_t                   f_op, q_op;
    logic [tcc_pkg::CODE_W-1:0]     f_code, q_code;
    logic [COL_W-1:0]               f_col, q_col;
    logic [ROW_W-1:0]               f_row, q_row;
    logic [Q_W-1:0]                 q_wdata, q_rdata;

    // config register, written in the apb access phase
    assign pready  = 1'b1;
    assign cfg_hit = psel && penable && pwrite && pready
                  && (paddr[tcc_pkg::PADDR_W-1] == tcc_pkg::REG_TEXT_ATTR);
    assign attr_next = cfg_hit ? pwdata[7:0] : attr_reg;
    assign prdata = (paddr[tcc_pkg::PADDR_W-1] == tcc_pkg::REG_TEXT_ATTR)
                  ? {{(tcc_pkg::PDATA_W - 8){1'b0}}, attr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= tcc_pkg::RESET_ATTR;
        else
            attr_reg <= attr_next;
    end

    // classify and clamp
    tcc_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .q_status   (q_status),
        .b_status   (b_status),
        .push       (push),
        .f_op       (f_op),
        .f_code     (f_code),
        .f_col      (f_col),
        .f_row      (f_row)
    );

    assign q_wdata = {f_op, f_code, f_col, f_row};

    tcc_fifo #(
        .WIDTH (Q_W),
        .DEPTH (tcc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (q_wdata),
        .pop      (pop),
        .rdata    (q_rdata),
        .q_status (q_status)
    );

    assign q_row  = q_rdata[ROW_W-1:0];
    assign q_col  = q_rdata[ROW_W +: COL_W];
    assign q_code = q_rdata[ROW_W + COL_W +: tcc_pkg::CODE_W];
    assign q_op   = tcc_pkg::op_t'(q_rdata[Q_W-1 -: tcc_pkg::OP_W]);

    // screen store and sequencer
    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_attr    (attr_reg),
        .q_status     (q_status),
        .q_op         (q_op),
        .q_code       (q_code),
        .q_col        (q_col),
        .q_row        (q_row),
        .pop          (pop),
        .b_status     (b_status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .cell_char    (cell_char),
        .cell_attr    (cell_attr),
        .scrolled     (scrolled)
    );

endmodule

// ===== design/tcc_front.sv =====
`timescale 1ns / 1ps
// front end: takes input words, classifies the command and clamps coordinates
// depends on tcc_pkg

module tcc_front #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF,
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS)
) (
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [tcc_pkg::CMD_W-1:0]     cmd,
    input  logic [tcc_pkg::CODE_W-1:0]    char_code,
    input  logic [tcc_pkg::COL_IN_W-1:0]  col,
    input  logic [tcc_pkg::ROW_IN_W-1:0]  row,
    input  tcc_pkg::fifo_status_t         q_status,
    input  tcc_pkg::back_status_t         b_status,
    output logic                          push,
    output tcc_pkg::op_t                  f_op,
    output logic [tcc_pkg::CODE_W-1:0]    f_code,
    output logic [COL_W-1:0]              f_col,
    output logic [ROW_W-1:0]              f_row
);

    assign item_ready = !q_status.full && !b_status.init_busy;
    assign push       = item_valid && item_ready;
    assign f_code     = char_code;

    // saturate coordinates to the screen
    assign f_col = (int'(col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(col);
    assign f_row = (int'(row) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(row);

    always_comb
    begin
        f_op = tcc_pkg::OP_NOP;
        unique case (tcc_pkg::cmd_t'(cmd))
            tcc_pkg::CMD_PUT:
            begin
                if (char_code == tcc_pkg::NEWLINE_CODE)
                    f_op = tcc_pkg::OP_NEWLINE;
                else if (char_code == tcc_pkg::NUL_CODE)
                    f_op = tcc_pkg::OP_NOP;
                else
                    f_op = tcc_pkg::OP_PUT;
            end
            tcc_pkg::CMD_GOTO:  f_op = tcc_pkg::OP_GOTO;
            tcc_pkg::CMD_CLEAR: f_op = tcc_pkg::OP_CLEAR;
            tcc_pkg::CMD_READ:  f_op = tcc_pkg::OP_READ;
            default:            f_op = tcc_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== design/tcc_fifo.sv =====
`timescale 1ns / 1ps
// short queue of classified words between front and back end
// depends on tcc_pkg

module tcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcc_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output tcc_pkg::fifo_status_t q_status
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== design/tcc_back.sv =====
`timescale 1ns / 1ps
// back end: screen store, cursor and the sequencer for writes, scrolls and clears
// depends on tcc_pkg

module tcc_back #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF,
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    text_attr,
    input  tcc_pkg::fifo_status_t         q_status,
    input  tcc_pkg::op_t                  q_op,
    input  logic [tcc_pkg::CODE_W-1:0]    q_code,
    input  logic [COL_W-1:0]              q_col,
    input  logic [ROW_W-1:0]              q_row,
    output logic                          pop,
    output tcc_pkg::back_status_t         b_status,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tcc_pkg::COL_IN_W-1:0]  cursor_x,
    output logic [tcc_pkg::ROW_IN_W-1:0]  cursor_y,
    output logic [7:0]                    cell_char,
    output logic [7:0]                    cell_attr,
    output logic                          scrolled
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    // screen store
    logic [tcc_pkg::CELL_W-1:0] screen_mem [CELLS];

    tcc_pkg::state_t            state_reg, state_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [ADDR_W-1:0]          sweep_reg, sweep_next;
    logic                       pend_reg, pend_next;
    logic [ADDR_W-1:0]          wa_reg, wa_next;
    logic [tcc_pkg::CELL_W-1:0] rdata_reg;
    logic                       valid_reg, valid_next;
    logic [7:0]                 char_reg, char_next;
    logic [7:0]                 attr_reg, attr_next;
    logic                       scrolled_reg, scrolled_next;

    logic                       we;
    logic [ADDR_W-1:0]          waddr, raddr;
    logic [tcc_pkg::CELL_W-1:0] wdata;
    logic [tcc_pkg::CELL_W-1:0] blank;
    logic [ADDR_W-1:0]          cur_addr, item_addr;
    logic                       can_take, at_last_col, at_last_row, wrap, sweep_done;

    assign blank       = {text_attr, tcc_pkg::SPACE_CODE};
    assign cur_addr    = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign item_addr   = ADDR_W'(q_row) * COLS_A + ADDR_W'(q_col);
    assign at_last_col = (col_reg == LAST_COL);
    assign at_last_row = (row_reg == LAST_ROW);
    assign wrap        = (q_op == tcc_pkg::OP_NEWLINE)
                      || ((q_op == tcc_pkg::OP_PUT) && at_last_col);
    assign sweep_done  = (sweep_reg == LAST_ADDR);
    assign can_take    = (state_reg == tcc_pkg::ST_IDLE) && !q_status.empty
                      && (!valid_reg || result_ready);

    assign b_status.init_busy = (state_reg == tcc_pkg::ST_INIT);
    assign result_valid = valid_reg;
    assign cursor_x     = tcc_pkg::COL_IN_W'(col_reg);
    assign cursor_y     = tcc_pkg::ROW_IN_W'(row_reg);
    assign cell_char    = char_reg;
    assign cell_attr    = attr_reg;
    assign scrolled     = scrolled_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcc_pkg::ST_INIT:
                if (sweep_done)
                    state_next = tcc_pkg::ST_IDLE;
            tcc_pkg::ST_IDLE:
                if (can_take)
                begin
                    unique case (q_op) inside
                        tcc_pkg::OP_READ:  state_next = tcc_pkg::ST_READ;
                        tcc_pkg::OP_CLEAR: state_next = tcc_pkg::ST_CLEAR;
                        tcc_pkg::OP_PUT, tcc_pkg::OP_NEWLINE:
                            if (wrap && at_last_row)
                                state_next = tcc_pkg::ST_SCROLL;
                        default:           state_next = tcc_pkg::ST_IDLE;
                    endcase
                end
            tcc_pkg::ST_READ:
                state_next = tcc_pkg::ST_IDLE;
            tcc_pkg::ST_SCROLL:
                if (sweep_done)
                    state_next = tcc_pkg::ST_BLANK;
            tcc_pkg::ST_BLANK:
                if (!pend_reg && sweep_done)
                    state_next = tcc_pkg::ST_IDLE;
            tcc_pkg::ST_CLEAR:
                if (sweep_done)
                    state_next = tcc_pkg::ST_IDLE;
            default:
                state_next = tcc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        sweep_next    = sweep_reg;
        pend_next     = 1'b0;
        wa_next       = sweep_reg - COLS_A;
        valid_next    = valid_reg && !result_ready;
        char_next     = char_reg;
        attr_next     = attr_reg;
        scrolled_next = scrolled_reg;
        we            = 1'b0;
        waddr         = sweep_reg;
        wdata         = blank;
        raddr         = sweep_reg;
        pop           = 1'b0;
        unique case (state_reg)
            tcc_pkg::ST_INIT:
            begin
                we         = 1'b1;
                wdata      = tcc_pkg::RESET_CELL;
                sweep_next = sweep_done ? '0 : sweep_reg + ADDR_W'(1);
            end
            tcc_pkg::ST_IDLE:
                if (can_take)
                begin
                    pop = 1'b1;
                    char_next     = '0;
                    attr_next     = '0;
                    scrolled_next = 1'b0;
                    unique case (q_op) inside
                        tcc_pkg::OP_NOP:
                            valid_next = 1'b1;
                        tcc_pkg::OP_GOTO:
                        begin
                            col_next   = q_col;
                            row_next   = q_row;
                            valid_next = 1'b1;
                        end
                        tcc_pkg::OP_PUT, tcc_pkg::OP_NEWLINE:
                        begin
                            if (q_op == tcc_pkg::OP_PUT)
                            begin
                                we    = 1'b1;
                                waddr = cur_addr;
                                wdata = {text_attr, q_code};
                            end
                            if (wrap)
                            begin
                                col_next = '0;
                                if (at_last_row)
                                    sweep_next = COLS_A;    // copy starts at row one
                                else
                                begin
                                    row_next   = row_reg + ROW_W'(1);
                                    valid_next = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + COL_W'(1);
                                valid_next = 1'b1;
                            end
                        end
                        tcc_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = LAST_ROW;
                            sweep_next = '0;
                        end
                        tcc_pkg::OP_READ:
                            raddr = item_addr;
                        default:
                            valid_next = 1'b1;
                    endcase
                end
            tcc_pkg::ST_READ:
            begin
                valid_next = 1'b1;
                char_next  = rdata_reg[7:0];
                attr_next  = rdata_reg[15:8];
            end
            tcc_pkg::ST_SCROLL:
            begin
                // read one row ahead, write the word read last cycle
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = wa_reg;
                    wdata = rdata_reg;
                end
                sweep_next = sweep_done ? BOTTOM_ADDR : sweep_reg + ADDR_W'(1);
            end
            tcc_pkg::ST_BLANK:
            begin
                we = 1'b1;
                if (pend_reg)
                begin
                    // last copied word still in flight
                    waddr = wa_reg;
                    wdata = rdata_reg;
                end
                else if (sweep_done)
                begin
                    sweep_next    = '0;
                    valid_next    = 1'b1;
                    scrolled_next = 1'b1;
                end
                else
                    sweep_next = sweep_reg + ADDR_W'(1);
            end
            tcc_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                if (sweep_done)
                begin
                    sweep_next = '0;
                    valid_next = 1'b1;
                end
                else
                    sweep_next = sweep_reg + ADDR_W'(1);
            end
            default:
                we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcc_pkg::ST_INIT;
            col_reg      <= '0;
            row_reg      <= LAST_ROW;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            sweep_reg    <= sweep_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
            scrolled_reg <= scrolled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg   <= wa_next;
        char_reg <= char_next;
        attr_reg <= attr_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            screen_mem[waddr] <= wdata;
        rdata_reg <= screen_mem[raddr];
    end

endmodule

// ===== design/tcc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the text console engine, bound to the top level
// depends on tcc_pkg and text_console_cursor_scroll

module tcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [tcc_pkg::COL_IN_W-1:0]  cursor_x,
    input logic [tcc_pkg::ROW_IN_W-1:0]  cursor_y,
    input logic [7:0]                    cell_char,
    input logic [7:0]                    cell_attr,
    input logic                          scrolled
);

    // a waiting result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(cursor_x)
            && $stable(cursor_y) && $stable(cell_char) && $stable(cell_attr)
            && $stable(scrolled))
        else $error("result word changed while stalled");

    // clearing pass keeps the input closed right after reset
    assert property (@(posedge clk) !rst_n |=> !item_ready)
        else $error("input accepted during clearing pass");

    // a scroll always leaves the cursor at column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && scrolled |-> cursor_x == '0)
        else $error("scroll with cursor off column zero");

    // a scrolling put or newline never reports cell data
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && scrolled |-> cell_char == '0 && cell_attr == '0)
        else $error("cell data on a scroll result");

endmodule

bind text_console_cursor_scroll tcc_checker u_tcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .scrolled     (scrolled)
);

// ===== sim/text_console_cursor_scroll_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the text console engine: directed table, then random words
// depends on tcc_pkg and text_console_cursor_scroll; keeps its own copy of screen and cursor

module text_console_cursor_scroll_test;

    // screen geometry, the block runs with its default parameters
    localparam int SCREEN_COLS  = tcc_pkg::COLUMNS_DEF;
    localparam int SCREEN_ROWS  = tcc_pkg::ROWS_DEF;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    // text_attr is the first register of the map
    localparam logic [tcc_pkg::PADDR_W-1:0] ATTR_ADDR =
        tcc_pkg::PADDR_W'(4 * int'(tcc_pkg::REG_TEXT_ATTR));

    // clears and scrolling newlines cost a full screen pass, so newlines and clears are capped
    localparam int HEAVY_CAP = 150;

    typedef struct packed {
        tcc_pkg::cmd_t cmd;
        logic [7:0]    code;
        logic [6:0]    col;
        logic [4:0]    row;
    } console_word_t;

    typedef struct packed {
        logic [6:0]  x;
        logic [4:0]  y;
        logic [7:0]  ch;
        logic [7:0]  at;
        logic        sc;
    } console_result_t;

    // one line of the directed table; typed rows carry their result written out
    typedef struct packed {
        console_word_t    w;
        logic             typed;
        console_result_t  r;
    } directed_row_t;

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [tcc_pkg::PADDR_W-1:0]   paddr        = '0;
    logic [tcc_pkg::PDATA_W-1:0]   pwdata       = '0;
    logic [tcc_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          item_valid   = 1'b0;
    logic                          item_ready;
    logic [tcc_pkg::CMD_W-1:0]     cmd          = '0;
    logic [tcc_pkg::CODE_W-1:0]    char_code    = '0;
    logic [tcc_pkg::COL_IN_W-1:0]  col          = '0;
    logic [tcc_pkg::ROW_IN_W-1:0]  row          = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    logic [tcc_pkg::COL_IN_W-1:0]  cursor_x;
    logic [tcc_pkg::ROW_IN_W-1:0]  cursor_y;
    logic [7:0]                    cell_char;
    logic [7:0]                    cell_attr;
    logic                          scrolled;

    text_console_cursor_scroll dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .char_code    (char_code),
        .col          (col),
        .row          (row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .cell_char    (cell_char),
        .cell_attr    (cell_attr),
        .scrolled     (scrolled)
    );

    // ------------------------------------------------------------------
    // own copy of the console: screen cells, cursor and attribute
    // ------------------------------------------------------------------
    logic [15:0]      screen_copy [0:SCREEN_CELLS-1];
    int               cur_col;
    int               cur_row;
    logic [7:0]       attr_copy;

    // expected result words, oldest first
    console_result_t  results_due [$];

    directed_row_t    directed_rows [0:24];

    // pacing: percent of cycles the sender idles and the receiver stalls
    int               idle_pct     = 0;
    int               stall_pct    = 0;
    // long receiver hold-off, driven by its own counting process
    logic             hold_results = 1'b0;

    int               fail_count   = 0;
    int               words_sent   = 0;
    int               results_seen = 0;
    int               scroll_count = 0;
    int               read_count   = 0;
    int               heavy_left   = HEAVY_CAP;

    // fill from a given cell to the end of the screen with blanks in the current attribute
    function automatic void blank_from(int first);
        for (int i = first; i < SCREEN_CELLS; i++)
            screen_copy[i] = {attr_copy, tcc_pkg::SPACE_CODE};
    endfunction

    // cursor to the start of the next line; from the last row the screen moves up
    function automatic logic roll_to_next_line();
        cur_col = 0;
        if (cur_row < SCREEN_ROWS - 1)
        begin
            cur_row++;
            return 1'b0;
        end
        for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
            screen_copy[i] = screen_copy[i + SCREEN_COLS];
        blank_from(SCREEN_CELLS - SCREEN_COLS);
        return 1'b1;
    endfunction

    // applies one word to the copy and works out the result word it gives
    task automatic screen_apply(input console_word_t w, output console_result_t r);
        int c;
        int rr;
        r = '0;
        c  = (int'(w.col) > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : int'(w.col);
        rr = (int'(w.row) > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : int'(w.row);
        case (w.cmd)
            tcc_pkg::CMD_PUT:
            begin
                if (w.code == tcc_pkg::NEWLINE_CODE)
                    r.sc = roll_to_next_line();
                else if (w.code != tcc_pkg::NUL_CODE)
                begin
                    screen_copy[cur_row * SCREEN_COLS + cur_col] = {attr_copy, w.code};
                    cur_col++;
                    // wrap at the end of the line
                    if (cur_col >= SCREEN_COLS)
                        r.sc = roll_to_next_line();
                end
            end
            tcc_pkg::CMD_GOTO:
            begin
                cur_col = c;
                cur_row = rr;
            end
            tcc_pkg::CMD_CLEAR:
            begin
                blank_from(0);
                cur_col = 0;
                cur_row = SCREEN_ROWS - 1;
            end
            default:
            begin
                r.ch = screen_copy[rr * SCREEN_COLS + c][7:0];
                r.at = screen_copy[rr * SCREEN_COLS + c][15:8];
            end
        endcase
        r.x = 7'(cur_col);
        r.y = 5'(cur_row);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // config port: write text_attr, then read it back
    // ------------------------------------------------------------------
    task automatic write_text_attr(input logic [7:0] value);
        // setup phase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        // access phase, register taken at the next edge
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        attr_copy = value;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        // prdata is settled well before the falling edge of the access phase
        @(negedge clk);
        check_field("text_attr readback", 32'(value), 32'(prdata[7:0]));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sender: one word per call, held until the block takes it
    // ------------------------------------------------------------------
    task automatic offer_word(input console_word_t w, input logic typed,
                              input console_result_t typed_res);
        console_result_t predicted;
        // random gap before this word; valid is only lowered when a gap is taken
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        item_valid <= 1'b1;
        cmd        <= w.cmd;
        char_code  <= w.code;
        col        <= w.col;
        row        <= w.row;
        do
            @(posedge clk);
        while (!item_ready);
        screen_apply(w, predicted);
        results_due.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    // random word: mostly characters of any code, with moves, reads, newlines, ignored codes, the odd clear
    function automatic console_word_t random_word();
        console_word_t w;
        int pick;
        w.cmd  = tcc_pkg::CMD_PUT;
        w.code = 8'($urandom_range(0, 255));
        // mostly on-screen positions, one in four anywhere the field allows
        w.col  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(0, SCREEN_COLS - 1));
        w.row  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, SCREEN_ROWS - 1));
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 64 && heavy_left > 0)
        begin
            w.code = tcc_pkg::NEWLINE_CODE;
            heavy_left--;
        end
        else if (pick >= 64 && pick < 66)
            w.code = tcc_pkg::NUL_CODE;
        else if (pick >= 66 && pick < 78)
            w.cmd = tcc_pkg::CMD_GOTO;
        else if (pick == 78 && heavy_left > 0)
        begin
            w.cmd = tcc_pkg::CMD_CLEAR;
            heavy_left--;
        end
        else if (pick >= 79)
            w.cmd = tcc_pkg::CMD_READ;
        // plain text here: keep newline and the ignored code out of it
        if (w.cmd == tcc_pkg::CMD_PUT && pick < 60 &&
            (w.code == tcc_pkg::NEWLINE_CODE || w.code == tcc_pkg::NUL_CODE))
            w.code = 8'h2e;
        return w;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            offer_word(random_word(), 1'b0, '0);
        // last word taken in this step, nothing else may follow it in
        item_valid <= 1'b0;
    endtask

    // sender holds off until every expected result word is back
    task automatic wait_results_drained();
        while (results_due.size() != 0)
            @(posedge clk);
        // every word gives a result, so a short pause leaves the block idle
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off while the flag is up
    // ------------------------------------------------------------------
    always @(posedge clk)
        result_ready <= !hold_results && ($urandom_range(0, 99) >= stall_pct);

    // result checker: each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (results_due.size() == 0)
            begin
                fail_count++;
                $error("result word with nothing expected");
            end
            else
            begin
                want = results_due.pop_front();
                results_seen++;
                if (want.sc)
                    scroll_count++;
                check_field("cursor_x", 32'(want.x), 32'(cursor_x));
                check_field("cursor_y", 32'(want.y), 32'(cursor_y));
                check_field("cell_char", 32'(want.ch), 32'(cell_char));
                check_field("cell_attr", 32'(want.at), 32'(cell_attr));
                check_field("scrolled", 32'(want.sc), 32'(scrolled));
            end
        end
    end

    always @(posedge clk)
        if (rst_n && item_valid && item_ready && cmd == tcc_pkg::CMD_READ)
            read_count++;

    // ------------------------------------------------------------------
    // directed table, run with the reset attribute; the cursor starts at
    // the bottom-left corner of a blank screen
    // ------------------------------------------------------------------
    initial
    begin
        // reads straight after reset, one of them far off screen
        directed_rows[0]  = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd0, 5'd0}, 1'b1,
                              '{7'd0, 5'd24, tcc_pkg::SPACE_CODE, tcc_pkg::RESET_ATTR,
                                1'b0}};
        directed_rows[1]  = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd127, 5'd31}, 1'b1,
                              '{7'd0, 5'd24, tcc_pkg::SPACE_CODE, tcc_pkg::RESET_ATTR,
                                1'b0}};
        // ignored code leaves everything alone
        directed_rows[2]  = '{'{tcc_pkg::CMD_PUT, tcc_pkg::NUL_CODE, 7'd0, 5'd0}, 1'b1,
                              '{7'd0, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[3]  = '{'{tcc_pkg::CMD_PUT, 8'h41, 7'd0, 5'd0}, 1'b1,
                              '{7'd1, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[4]  = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd0, 5'd24}, 1'b1,
                              '{7'd1, 5'd24, 8'h41, tcc_pkg::RESET_ATTR, 1'b0}};
        directed_rows[5]  = '{'{tcc_pkg::CMD_PUT, 8'hff, 7'd0, 5'd0}, 1'b1,
                              '{7'd2, 5'd24, 8'd0, 8'd0, 1'b0}};
        // last column of the last row: the next character wraps and scrolls
        directed_rows[6]  = '{'{tcc_pkg::CMD_GOTO, tcc_pkg::NUL_CODE, 7'd79, 5'd24}, 1'b1,
                              '{7'd79, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[7]  = '{'{tcc_pkg::CMD_PUT, 8'h5a, 7'd0, 5'd0}, 1'b1,
                              '{7'd0, 5'd24, 8'd0, 8'd0, 1'b1}};
        directed_rows[8]  = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd79, 5'd23}, 1'b1,
                              '{7'd0, 5'd24, 8'h5a, tcc_pkg::RESET_ATTR, 1'b0}};
        // fresh bottom row is blank
        directed_rows[9]  = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd0, 5'd24}, 1'b1,
                              '{7'd0, 5'd24, tcc_pkg::SPACE_CODE, tcc_pkg::RESET_ATTR,
                                1'b0}};
        // goto out of range saturates
        directed_rows[10] = '{'{tcc_pkg::CMD_GOTO, tcc_pkg::NUL_CODE, 7'd127, 5'd31}, 1'b1,
                              '{7'd79, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[11] = '{'{tcc_pkg::CMD_GOTO, tcc_pkg::NUL_CODE, 7'd0, 5'd0}, 1'b1,
                              '{7'd0, 5'd0, 8'd0, 8'd0, 1'b0}};
        // newline away from the last row does not scroll
        directed_rows[12] = '{'{tcc_pkg::CMD_PUT, tcc_pkg::NEWLINE_CODE, 7'd0, 5'd0}, 1'b0,
                              '0};
        directed_rows[13] = '{'{tcc_pkg::CMD_PUT, 8'h01, 7'd0, 5'd0}, 1'b0, '0};
        directed_rows[14] = '{'{tcc_pkg::CMD_GOTO, tcc_pkg::NUL_CODE, 7'd5, 5'd23}, 1'b1,
                              '{7'd5, 5'd23, 8'd0, 8'd0, 1'b0}};
        directed_rows[15] = '{'{tcc_pkg::CMD_PUT, tcc_pkg::NEWLINE_CODE, 7'd0, 5'd0}, 1'b1,
                              '{7'd0, 5'd24, 8'd0, 8'd0, 1'b0}};
        // newline on the last row scrolls
        directed_rows[16] = '{'{tcc_pkg::CMD_PUT, tcc_pkg::NEWLINE_CODE, 7'd0, 5'd0}, 1'b1,
                              '{7'd0, 5'd24, 8'd0, 8'd0, 1'b1}};
        directed_rows[17] = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd0, 5'd22}, 1'b0,
                              '0};
        directed_rows[18] = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd0, 5'd0}, 1'b0,
                              '0};
        // clear, then a read that saturates only the column
        directed_rows[19] = '{'{tcc_pkg::CMD_CLEAR, 8'hff, 7'd127, 5'd31}, 1'b1,
                              '{7'd0, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[20] = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd80, 5'd0}, 1'b1,
                              '{7'd0, 5'd24, tcc_pkg::SPACE_CODE, tcc_pkg::RESET_ATTR,
                                1'b0}};
        directed_rows[21] = '{'{tcc_pkg::CMD_GOTO, tcc_pkg::NUL_CODE, 7'd0, 5'd25}, 1'b1,
                              '{7'd0, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[22] = '{'{tcc_pkg::CMD_PUT, 8'h80, 7'd0, 5'd0}, 1'b1,
                              '{7'd1, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[23] = '{'{tcc_pkg::CMD_PUT, tcc_pkg::SPACE_CODE, 7'd0, 5'd0}, 1'b1,
                              '{7'd2, 5'd24, 8'd0, 8'd0, 1'b0}};
        directed_rows[24] = '{'{tcc_pkg::CMD_READ, tcc_pkg::NUL_CODE, 7'd1, 5'd24}, 1'b0,
                              '0};
    end

    // ------------------------------------------------------------------
    // clock, main sequence and time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        logic [7:0] mid_attr;
        // copy starts from the reset screen
        attr_copy = tcc_pkg::RESET_ATTR;
        blank_from(0);
        cur_col = 0;
        cur_row = SCREEN_ROWS - 1;
        mid_attr = 8'($urandom_range(1, 254));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; the sender waits out the clearing pass after reset
        foreach (directed_rows[i])
            offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);
        item_valid <= 1'b0;
        wait_results_drained();

        // back to back, attribute at its low extreme
        write_text_attr(8'h00);
        run_random(400);
        wait_results_drained();

        // sender mostly idle, attribute at its high extreme
        write_text_attr(8'hff);
        idle_pct = 80;
        run_random(400);
        wait_results_drained();

        // receiver mostly stalling
        write_text_attr(mid_attr);
        idle_pct = 0;
        stall_pct <= 80;
        run_random(400);
        wait_results_drained();

        // receiver holds off for a long stretch while words keep coming,
        // so the queue fills and the block stops taking words
        write_text_attr(tcc_pkg::RESET_ATTR);
        stall_pct <= 0;
        fork
            begin
                hold_results <= 1'b1;
                repeat (400) @(posedge clk);
                hold_results <= 1'b0;
            end
            run_random(50);
        join
        wait_results_drained();

        // both sides idle now and then
        idle_pct = 23;
        stall_pct <= 23;
        run_random(400);
        wait_results_drained();
        // room for a stray result word to show up
        repeat (50) @(posedge clk);

        if (results_due.size() != 0)
        begin
            fail_count++;
            $error("%0d result words never arrived", results_due.size());
        end
        $display("%0d words sent under five pacing settings, text_attr 0, 255, %0d and 15",
                 words_sent, mid_attr);
        $display("%0d result words checked, %0d scrolls, %0d cell reads",
                 results_seen, scroll_count, read_count);
        if (fail_count == 0)
            $display("text_console_cursor_scroll_test passed");
        else
            $display("text_console_cursor_scroll_test failed");
        $finish;
    end

    // far beyond the slowest correct run: capped newlines and clears at a full screen
    // pass each, the wrap scrolls, the clearing pass after reset and all stalls
    initial
    begin
        #8000000;
        $display("text_console_cursor_scroll_test failed");
        $finish;
    end

endmodule
